// ----- rtl/ttps_pkg.sv -----
// Shared types, codes and constants for the transposition table probe/store block.
package ttps_pkg;

   localparam int NUM_BUCKETS_DEF = 16384;
   localparam int WAYS_DEF        = 3;
   localparam int IDX_W           = 14;
   localparam int MOD_STEPS       = 2;    // reciprocal multiply, then multiply-subtract

   localparam logic [7:0]  AGE_INC    = 8'h08;
   localparam logic [7:0]  AGE_FIELD  = 8'hF8;
   localparam logic [7:0]  AGE_WRAP   = 8'h07;   // (255 + 8) mod 256
   localparam logic [14:0] WIN_RST    = 15'd31000;
   localparam logic [15:0] NONE_RST   = 16'h7D02;
   localparam logic [1:0]  EXACT_RST  = 2'd3;

   typedef enum logic [1:0] {
      OP_PROBE = 2'd0,
      OP_STORE = 2'd1,
      OP_AGE   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   localparam logic [1:0] CSR_WIN   = 2'd0;
   localparam logic [1:0] CSR_NONE  = 2'd1;
   localparam logic [1:0] CSR_EXACT = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_SCAN,
      ST_WRITE,
      ST_CLEAR,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type             opcode;
      logic [13:0]        bucket_index;
      logic [15:0]        entry_key;
      logic [1:0]         target_way;
      logic [15:0]        best_move;
      logic signed [15:0] search_score;
      logic signed [15:0] static_eval;
      logic [1:0]         bound_kind;
      logic signed [7:0]  search_depth;
      logic [7:0]         ply_from_root;
      logic               pv_node;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [1:0]         chosen_way;
      logic [15:0]        found_move;
      logic signed [15:0] found_score;
      logic signed [15:0] found_eval;
      logic signed [7:0]  found_depth;
      logic [1:0]         found_bound;
      logic               found_pv;
      logic               op_done;
   } rsp_type;

   // one way of a bucket; flags hold age in [7:3], pv in [2], bound in [1:0]
   typedef struct packed {
      logic [15:0]        key;
      logic [15:0]        move;
      logic signed [7:0]  depth;
      logic [7:0]         flags;
      logic signed [15:0] score;
      logic signed [15:0] eval;
   } entry_type;

endpackage

// ----- rtl/ttps_req_if.sv -----
// Request channel interface: valid/ready with one request item.
interface ttps_req_if
   import ttps_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ttps_rsp_if.sv -----
// Response channel interface: valid/ready with one response item.
interface ttps_rsp_if
   import ttps_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/transposition_table_probe_store.sv -----
// Top level of the transposition table probe/store block.
//
//  channel   dir   handshake          payload
//  req_chan  in    valid/ready        req_type (one operation)
//  rsp_chan  out   valid/ready        rsp_type (one result per operation)
//  csr_*     in    csr_we             csr_index, csr_wdata (no read-back)
//
// A bucket is one memory row holding all ways. Probe: a read step, one way
// per cycle through the shared compare/score unit (stops at the first match
// or empty way), a write-back step, then the result. Store: read, write,
// result. Advance age goes straight to the result. A non-power-of-two
// bucket count below 16384 adds the modulo steps before the read.
// After reset and on a clear operation, a sweep writes NUM_BUCKETS rows, one
// per cycle; no item is taken meanwhile. A stalled result holds off new items.
module transposition_table_probe_store
   import ttps_pkg::*;
#(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
   parameter int WAYS        = WAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ttps_req_if.sink    req_chan,
   ttps_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int WAY_W    = $clog2(WAYS);
   localparam bit POW2     = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
   localparam bit NEED_MOD = (NUM_BUCKETS < (1 << IDX_W)) && !POW2;
   localparam int RECIP_SH = IDX_W + BKT_W;
   localparam logic [IDX_W+1:0] RECIP = (IDX_W+2)'(((64'd1 << RECIP_SH)
                                        + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

   typedef entry_type [WAYS-1:0] row_type;

   // control and config registers
   state_type         state_ff, state_in;
   logic [7:0]        age_ff, age_in;
   logic [14:0]       win_ff;
   logic [15:0]       none_ff;
   logic [1:0]        exact_ff;
   logic [BKT_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [3:0]        step_ff, step_in;
   logic [WAY_W-1:0]  way_ff, way_in;

   // datapath registers
   req_type           item_ff, item_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  quot_ff, quot_in;
   row_type           row_rd_ff;
   logic              found_ff, found_in;
   logic              hit_ff, hit_in;
   logic [WAY_W-1:0]  fway_ff, fway_in;
   logic [WAY_W-1:0]  bway_ff, bway_in;
   logic signed [11:0] best_ff, best_in;
   rsp_type           rsp_ff, rsp_in;

   // table memory
   row_type           tbl_mem [NUM_BUCKETS];
   logic              mem_we;
   logic [BKT_W-1:0]  mem_addr;
   row_type           mem_wdata;

   logic              req_acc;
   logic              rsp_acc;
   logic [BKT_W-1:0]  row_idx;
   logic [IDX_W+BKT_W-1:0] idx_ext;
   logic [2*IDX_W+1:0] mod_prod;
   logic [2*IDX_W-1:0] mod_qn;
   logic              scan_match;
   logic signed [11:0] scan_val;
   entry_type         scan_e;
   logic [7:0]        scan_rel;
   logic              scan_last;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_RESP);
   assign rsp_chan.data  = rsp_ff;

   // bucket row from the reduced index
   always_comb begin
      idx_ext = {{BKT_W{1'b0}}, rem_ff};
      row_idx = idx_ext[BKT_W-1:0];
   end

   // modulo products: quotient estimate, then quotient times bucket count
   always_comb begin
      mod_prod = (2*IDX_W+2)'(rem_ff) * (2*IDX_W+2)'(RECIP);
      mod_qn   = (2*IDX_W)'(quot_ff) * (2*IDX_W)'(NUM_BUCKETS);
   end

   // shared scan unit: match test and replacement score of one way
   always_comb begin
      scan_e     = row_rd_ff[way_ff];
      scan_match = (scan_e.key == item_ff.entry_key) || (scan_e.key == 16'd0);
      scan_rel   = (AGE_WRAP + age_ff - scan_e.flags) & AGE_FIELD;
      scan_val   = {{4{scan_e.depth[7]}}, scan_e.depth} - $signed({2'b00, scan_rel, 2'b00});
      scan_last  = (way_ff == WAY_W'(WAYS - 1));
   end

   // store merge unit
   logic [WAY_W+1:0]   tw_ext;
   logic [WAY_W-1:0]   tw_idx;
   logic               tw_ok;
   entry_type          st_old, st_new;
   logic               st_keychg;
   logic [15:0]        st_move;
   logic signed [17:0] thr18, sc18, sa18, sb18;
   logic signed [15:0] s1, s2;
   logic signed [9:0]  d_new, d_old;
   logic               st_over;

   always_comb begin
      tw_ext    = {{WAY_W{1'b0}}, item_ff.target_way};
      tw_idx    = tw_ext[WAY_W-1:0];
      tw_ok     = tw_ext < (WAY_W+2)'(WAYS);
      st_old    = row_rd_ff[tw_idx];
      st_keychg = st_old.key != item_ff.entry_key;
      st_move   = (item_ff.best_move != 16'd0 || st_keychg) ? item_ff.best_move : st_old.move;
      thr18     = $signed({3'b000, win_ff});
      // win adjust, then loss adjust on the adjusted score
      sc18 = {{2{item_ff.search_score[15]}}, item_ff.search_score};
      sa18 = sc18 + $signed({10'd0, item_ff.ply_from_root});
      if (sc18 >= thr18) begin
         if (sa18 > 18'sd32767)       s1 = 16'sh7FFF;
         else if (sa18 < -18'sd32768) s1 = 16'sh8000;
         else                         s1 = sa18[15:0];
      end else begin
         s1 = item_ff.search_score;
      end
      sb18 = {{2{s1[15]}}, s1} - $signed({10'd0, item_ff.ply_from_root});
      if ($signed({{2{s1[15]}}, s1}) <= -thr18) begin
         if (sb18 > 18'sd32767)       s2 = 16'sh7FFF;
         else if (sb18 < -18'sd32768) s2 = 16'sh8000;
         else                         s2 = sb18[15:0];
      end else begin
         s2 = s1;
      end
      if (item_ff.search_score == $signed(none_ff)) s2 = item_ff.search_score;
      d_new = {{2{item_ff.search_depth[7]}}, item_ff.search_depth} + 10'sd4
              + $signed({8'd0, item_ff.pv_node, 1'b0});
      d_old = {{2{st_old.depth[7]}}, st_old.depth};
      st_over = (item_ff.bound_kind == exact_ff) || st_keychg || (d_new > d_old);
      if (st_over) begin
         st_new.key   = item_ff.entry_key;
         st_new.move  = st_move;
         st_new.depth = item_ff.search_depth;
         st_new.flags = {5'd0, item_ff.pv_node, item_ff.bound_kind} | age_ff;
         st_new.score = s2;
         st_new.eval  = item_ff.static_eval;
      end else begin
         st_new      = st_old;
         st_new.move = st_move;
      end
   end

   // probe write-back and result fields
   logic [WAY_W-1:0] sel_way;
   logic [WAY_W+1:0] sel_ext;
   entry_type        sel_e;
   row_type          probe_row, store_row;

   always_comb begin
      sel_way = found_ff ? fway_ff : bway_ff;
      sel_ext = {2'b00, sel_way};
      sel_e   = row_rd_ff[sel_way];
      probe_row = row_rd_ff;
      probe_row[sel_way].flags = age_ff | (sel_e.flags & (AGE_INC - 8'd1));
      store_row = row_rd_ff;
      store_row[tw_idx] = st_new;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:  if (clr_ptr_ff == BKT_W'(NUM_BUCKETS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_chan.data.opcode)
                  OP_AGE:   state_in = ST_RESP;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = NEED_MOD ? ST_MOD : ST_READ;
               endcase
            end
         end
         ST_MOD:   if (step_ff == 4'd0) state_in = ST_READ;
         ST_READ:  state_in = (item_ff.opcode == OP_PROBE) ? ST_SCAN : ST_WRITE;
         ST_SCAN:  if (scan_match || scan_last) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_RESP;
         ST_CLEAR: if (clr_ptr_ff == BKT_W'(NUM_BUCKETS - 1)) state_in = ST_RESP;
         ST_RESP:  if (rsp_acc) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory write port and datapath next values
   always_comb begin
      mem_we     = 1'b0;
      mem_addr   = row_idx;
      mem_wdata  = store_row;
      clr_ptr_in = clr_ptr_ff;
      age_in     = age_ff;
      item_in    = item_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      step_in    = step_ff;
      way_in     = way_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      fway_in    = fway_ff;
      bway_in    = bway_ff;
      best_in    = best_ff;
      rsp_in     = rsp_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_addr   = clr_ptr_ff;
            mem_wdata  = '0;
            clr_ptr_in = clr_ptr_ff + BKT_W'(1);
            if (clr_ptr_ff == BKT_W'(NUM_BUCKETS - 1)) clr_ptr_in = '0;
            if (state_ff == ST_CLEAR) age_in = 8'd0;
         end
         ST_IDLE: begin
            if (req_acc) begin
               item_in  = req_chan.data;
               rem_in   = POW2 ? (req_chan.data.bucket_index & IDX_W'(NUM_BUCKETS - 1))
                               : req_chan.data.bucket_index;
               step_in  = 4'(MOD_STEPS - 1);
               way_in   = '0;
               found_in = 1'b0;
               hit_in   = 1'b0;
               bway_in  = '0;
               rsp_in   = '0;
               rsp_in.op_done = 1'b1;
               if (req_chan.data.opcode == OP_AGE) age_in = age_ff + AGE_INC;
            end
         end
         ST_MOD: begin
            // quotient by reciprocal multiply, then subtract quotient times count
            if (step_ff == 4'd1) quot_in = IDX_W'(mod_prod >> RECIP_SH);
            else                 rem_in  = rem_ff - mod_qn[IDX_W-1:0];
            step_in = step_ff - 4'd1;
         end
         ST_SCAN: begin
            if (scan_match) begin
               found_in = 1'b1;
               fway_in  = way_ff;
               hit_in   = scan_e.key == item_ff.entry_key;
            end else begin
               if (way_ff == '0 || scan_val < best_ff) begin
                  best_in = scan_val;
                  bway_in = way_ff;
               end
               if (!scan_last) way_in = way_ff + WAY_W'(1);
            end
         end
         ST_WRITE: begin
            if (item_ff.opcode == OP_PROBE) begin
               mem_we    = found_ff;
               mem_wdata = probe_row;
               rsp_in.hit         = hit_ff;
               rsp_in.chosen_way  = sel_ext[1:0];
               rsp_in.found_move  = sel_e.move;
               rsp_in.found_score = sel_e.score;
               rsp_in.found_eval  = sel_e.eval;
               rsp_in.found_depth = sel_e.depth;
               rsp_in.found_bound = sel_e.flags[1:0];
               rsp_in.found_pv    = sel_e.flags[2];
            end else begin
               mem_we = tw_ok;
            end
         end
         default: ;
      endcase
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) tbl_mem[mem_addr] <= mem_wdata;
      if (state_ff == ST_READ) row_rd_ff <= tbl_mem[row_idx];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         age_ff     <= 8'd0;
         clr_ptr_ff <= '0;
         step_ff    <= '0;
         way_ff     <= '0;
         found_ff   <= 1'b0;
         win_ff     <= WIN_RST;
         none_ff    <= NONE_RST;
         exact_ff   <= EXACT_RST;
      end else begin
         state_ff   <= state_in;
         age_ff     <= age_in;
         clr_ptr_ff <= clr_ptr_in;
         step_ff    <= step_in;
         way_ff     <= way_in;
         found_ff   <= found_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WIN:   win_ff   <= csr_wdata[14:0];
               CSR_NONE:  none_ff  <= csr_wdata;
               CSR_EXACT: exact_ff <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      hit_ff  <= hit_in;
      fway_ff <= fway_in;
      bway_ff <= bway_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   // checks
   a_age_step: assert property (@(posedge clock) disable iff (reset)
      age_ff[2:0] == 3'd0) else $error("age lost its step alignment");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid)) else $error("ready while result pending");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_chan.ready) else $error("item taken while busy");
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.data.op_done) else $error("result without done flag");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the transposition table probe/store block: scoreboard against a behavioral table.
module tb;
   import ttps_pkg::*;

   localparam int NW = 3;
   localparam int LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_WIN;
   logic [15:0] csr_wdata = '0;

   ttps_req_if req_chan ();
   ttps_rsp_if rsp_chan ();

   transposition_table_probe_store dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // behavioral copy of the table, sparse
   entry_type table_mem [int];
   logic [7:0] cur_age;
   logic [14:0] win_thr;
   logic signed [15:0] none_val;
   logic [1:0] exact_code;
   rsp_type expected_rsp [$];
   int failures = 0;
   int cycles = 0;
   int rsp_wait = 0;
   logic [13:0] hot_bucket;

   function automatic entry_type read_entry(int idx);
      entry_type e;
      e = '0;
      if (table_mem.exists(idx)) e = table_mem[idx];
      return e;
   endfunction

   function automatic int way_rank(entry_type e);
      logic [7:0] rel;
      rel = (8'h07 + cur_age - e.flags) & 8'hF8;
      return int'(e.depth) - 4 * int'(rel);
   endfunction

   function automatic logic signed [15:0] sat_score(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // compute the result of one operation and update the table copy
   function automatic rsp_type apply_op(req_type r);
      rsp_type o;
      int base, way, best, v, sc, thr;
      bit found;
      entry_type e;
      o = '0;
      o.op_done = 1'b1;
      base = int'(r.bucket_index) * NW;
      way = 0;
      found = 0;
      case (r.opcode)
         OP_PROBE: begin
            for (int i = 0; i < NW; i++) begin
               e = read_entry(base + i);
               if (!found && (e.key == r.entry_key || e.key == 0)) begin
                  e.flags = cur_age | (e.flags & 8'h07);
                  table_mem[base + i] = e;
                  o.hit = (e.key == r.entry_key);
                  way = i;
                  found = 1;
               end
            end
            if (!found) begin
               best = way_rank(read_entry(base));
               for (int i = 1; i < NW; i++) begin
                  v = way_rank(read_entry(base + i));
                  if (v < best) begin
                     best = v;
                     way = i;
                  end
               end
            end
            e = read_entry(base + way);
            o.chosen_way = way[1:0];
            o.found_move = e.move;
            o.found_score = e.score;
            o.found_eval = e.eval;
            o.found_depth = e.depth;
            o.found_bound = e.flags[1:0];
            o.found_pv = e.flags[2];
         end
         OP_STORE: begin
            if (r.target_way < NW) begin
               e = read_entry(base + r.target_way);
               sc = int'(r.search_score);
               thr = int'(win_thr);
               if (r.search_score != none_val) begin
                  if (sc >= thr) sc = sat_score(sc + int'(r.ply_from_root));
                  if (sc <= -thr) sc = sat_score(sc - int'(r.ply_from_root));
               end
               if (r.best_move != 0 || e.key != r.entry_key) e.move = r.best_move;
               if (r.bound_kind == exact_code || e.key != r.entry_key ||
                   int'(r.search_depth) + 4 + 2 * int'(r.pv_node) > int'(e.depth)) begin
                  e.key = r.entry_key;
                  e.depth = r.search_depth;
                  e.flags = ({5'd0, r.pv_node, r.bound_kind}) | cur_age;
                  e.score = sc[15:0];
                  e.eval = r.static_eval;
               end
               table_mem[base + r.target_way] = e;
            end
         end
         OP_AGE: cur_age = cur_age + 8'h08;
         default: begin
            table_mem.delete();
            cur_age = '0;
         end
      endcase
      return o;
   endfunction

   // send one item after a random gap; valid stays high into a zero gap
   task automatic send_item(req_type r);
      int gap;
      gap = $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_rsp.push_back(apply_op(r));
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WIN: win_thr = val[14:0];
         CSR_NONE: none_val = val;
         default: exact_code = val[1:0];
      endcase
      @(posedge clock);
   endtask

   function automatic req_type rand_req(op_type op);
      req_type r;
      r = req_type'($bits(req_type)'({$urandom, $urandom, $urandom, $urandom}));
      r.opcode = op;
      r.bucket_index = ($urandom_range(0, 3) == 0) ? 14'($urandom)
                                                   : 14'(hot_bucket + $urandom_range(0, 1));
      if ($urandom_range(0, 2) != 0) r.entry_key = 16'($urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) r.search_depth = 8'($urandom_range(0, 12));
      if ($urandom_range(0, 2) == 0) r.search_score = 16'($urandom_range(30990, 32767) *
         (($urandom & 1) ? 1 : -1));
      return r;
   endfunction

   // result checker; each result waits a drawn number of cycles
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t unexpected result: actual %h", $time, rsp_chan.data);
               failures++;
            end else begin
               exp_r = expected_rsp.pop_front();
               if (rsp_chan.data !== exp_r) begin
                  $display("%0t result mismatch: expected %h actual %h", $time, exp_r,
                           rsp_chan.data);
                  failures++;
               end
            end
            rsp_wait = $urandom_range(0, 15);
         end
         if (rsp_wait > 0 && rsp_chan.valid) rsp_wait--;
         rsp_chan.ready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_directed();
      req_type r;
      hot_bucket = 14'd16383;
      r = '0;
      r.opcode = OP_PROBE;
      send_item(r);                           // zero key on empty bucket
      for (int w = 0; w < 4; w++) begin       // fill ways, incl. one beyond range
         r = '1;
         r.opcode = OP_STORE;
         r.target_way = 2'(w);
         r.entry_key = 16'(16'h100 + w);
         r.search_depth = (w == 1) ? -8'sd128 : 8'sd127;
         r.search_score = (w == 0) ? 16'sh7fff : -16'sh8000;
         r.pv_node = w[0];
         send_item(r);
      end
      r.opcode = OP_AGE;
      send_item(r);
      r = '0;
      r.opcode = OP_PROBE;
      r.bucket_index = '1;
      r.entry_key = 16'hbeef;
      send_item(r);                           // full bucket miss: replacement pick
      r.entry_key = 16'h101;
      send_item(r);
      r.opcode = OP_CLEAR;
      send_item(r);
      r.opcode = OP_PROBE;
      send_item(r);
   endtask

   task automatic test_random(int count);
      int k;
      op_type op;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         op = (k < 45) ? OP_PROBE : (k < 90) ? OP_STORE : (k < 99) ? OP_AGE : OP_CLEAR;
         if (k % 30 == 0) hot_bucket = 14'($urandom);
         send_item(rand_req(op));
      end
   endtask

   task automatic test_settings();
      write_csr(CSR_WIN, 16'd0);
      write_csr(CSR_NONE, 16'h8000);
      write_csr(CSR_EXACT, 16'd0);
      test_random(300);
      wait_idle();
      write_csr(CSR_WIN, 16'h7fff);
      write_csr(CSR_NONE, 16'h7fff);
      write_csr(CSR_EXACT, 16'd2);
      test_random(250);
      wait_idle();
      write_csr(CSR_WIN, 16'd31000);
      write_csr(CSR_NONE, 16'd31005);
      write_csr(CSR_EXACT, 16'd1);
      test_random(250);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      cur_age = '0;
      win_thr = WIN_RST;
      none_val = NONE_RST;
      exact_code = EXACT_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300);
      wait_idle();
      test_settings();
      wait_idle();
      repeat (30) @(posedge clock);
      if (failures == 0 && expected_rsp.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/ttps_pkg.sv
rtl/ttps_req_if.sv
rtl/ttps_rsp_if.sv
rtl/transposition_table_probe_store.sv
tb/sv/tb.sv
